>>> src/crc32cs_pkg.sv
// Package: shared types, register indexes and CRC-32C fold matrices.
`timescale 1ns / 1ps

package crc32cs_pkg;

  // Reflected CRC-32C polynomial.
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;

  localparam int CRC_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int FOLD_MAX = 4;                   // most bytes folded by one item
  localparam int VEC_W    = CRC_W + FOLD_MAX * BYTE_W;
  localparam int FILL_W   = 2;
  localparam int GRP_W    = (FOLD_MAX - 1) * BYTE_W;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP = 1'b1;

  // Pending bytes of a swap group; the earliest byte sits in bits 7..0.
  typedef struct packed {
    logic [GRP_W-1:0]  bytes;
    logic [FILL_W-1:0] fill;
  } grp_t;

  // For each byte count (1 to 4) and each CRC output bit, the mask of the
  // input vector {data, crc} bits that feed it.
  typedef logic [FOLD_MAX-1:0][CRC_W-1:0][VEC_W-1:0] crc_rows_t;

  // Bitwise fold of one byte; only evaluated on constants at elaboration.
  function automatic logic [CRC_W-1:0] fold_byte_f(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Builds the fold matrices by pushing each single input bit through the
  // bitwise CRC. The fold is linear, so XOR of the columns gives the result.
  function automatic crc_rows_t gen_rows();
    crc_rows_t rows;
    logic [CRC_W-1:0] c;
    logic [FOLD_MAX*BYTE_W-1:0] d;
    rows = '0;
    for (int kk = 0; kk < FOLD_MAX; kk++) begin
      for (int j = 0; j < VEC_W; j++) begin
        c = '0;
        d = '0;
        if (j < CRC_W) begin
          c[j] = 1'b1;
        end else begin
          d[j-CRC_W] = 1'b1;
        end
        for (int bi = 0; bi <= kk; bi++) begin
          c = fold_byte_f(c, d[BYTE_W*bi +: BYTE_W]);
        end
        for (int o = 0; o < CRC_W; o++) begin
          rows[kk][o][j] = c[o];
        end
      end
    end
    return rows;
  endfunction

  localparam crc_rows_t CRC_ROWS = gen_rows();

endpackage

>>> src/crc32c_with_dword_swap_top.sv
// Top level: CRC-32C over a byte stream with optional dword byte swap.
//
//   Channel  Ports                               Direction  Moves
//   in       in_valid in_stall in_data_byte ...  into block one message byte per item
//   out      out_valid out_stall out_crc_result  out        one CRC per message
//   cfg      cfg_we cfg_index cfg_wdata          into block seed and swap mode writes
//
// One byte is taken every cycle while the input does not stall; a byte is held in
// the input register and its CRC, if it ends a message, is then loaded into the result
// register. The fold of up to four bytes against the CRC register sets the path.
// Reset clears seed, mode, CRC register and pending group. A stalled result
// holds the result register; non-final bytes still flow past it, and the input
// stalls only when a final byte waits for a full result register.
`timescale 1ns / 1ps

module crc32c_with_dword_swap_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [crc32cs_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [crc32cs_pkg::CRC_W-1:0]     out_crc_result,
  input  logic                              cfg_we,
  input  logic [crc32cs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crc32cs_pkg::CRC_W-1:0]     cfg_wdata
);

  logic [crc32cs_pkg::CRC_W-1:0]  seed_r, seed_nxt;
  logic                           swap_r, swap_nxt;
  logic [crc32cs_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  crc32cs_pkg::grp_t              grp_r, grp_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  logic [crc32cs_pkg::BYTE_W-1:0] s1_byte_r;
  logic                           s1_last_r;
  logic                           out_valid_r, out_valid_nxt;
  logic [crc32cs_pkg::CRC_W-1:0]  out_crc_r;

  logic                           out_free;
  logic                           s1_go;
  logic                           in_acc;
  logic [crc32cs_pkg::CRC_W-1:0]  fold_crc;
  crc32cs_pkg::grp_t              fold_grp;

  // Handshake control.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  crc32cs_fold u_fold (
    .crc       (crc_r),
    .grp       (grp_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .swap      (swap_r),
    .crc_nxt   (fold_crc),
    .grp_nxt   (fold_grp)
  );

  // Configuration and CRC state. A seed write restarts the message.
  always_comb begin
    seed_nxt = seed_r;
    swap_nxt = swap_r;
    crc_nxt  = crc_r;
    grp_nxt  = grp_r;
    if (s1_go) begin
      if (s1_last_r) begin
        crc_nxt = seed_r;
        grp_nxt = '0;
      end else begin
        crc_nxt = fold_crc;
        grp_nxt = fold_grp;
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        crc32cs_pkg::REG_SEED: begin
          seed_nxt = cfg_wdata;
          crc_nxt  = cfg_wdata;
          grp_nxt  = '0;
        end
        crc32cs_pkg::REG_SWAP: begin
          swap_nxt = cfg_wdata[0];
        end
        default: begin
          seed_nxt = seed_r;
        end
      endcase
    end
  end

  // Valid flags of the input and result registers.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= '0;
      swap_r      <= 1'b0;
      crc_r       <= '0;
      grp_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      swap_r      <= swap_nxt;
      crc_r       <= crc_nxt;
      grp_r       <= grp_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_go && s1_last_r) begin
      out_crc_r <= fold_crc;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_crc_result = out_crc_r;

endmodule

>>> src/crc32cs_fold.sv
// Fold unit: orders pending and new bytes and folds up to four bytes at once.
`timescale 1ns / 1ps

module crc32cs_fold (
  input  logic [crc32cs_pkg::CRC_W-1:0]  crc,
  input  crc32cs_pkg::grp_t              grp,
  input  logic [crc32cs_pkg::BYTE_W-1:0] data_byte,
  input  logic                           last_byte,
  input  logic                           swap,
  output logic [crc32cs_pkg::CRC_W-1:0]  crc_nxt,
  output crc32cs_pkg::grp_t              grp_nxt
);

  logic                                         fold_en;
  logic                                         full_grp;
  logic [crc32cs_pkg::FOLD_MAX*crc32cs_pkg::BYTE_W-1:0] fold_data;
  logic [crc32cs_pkg::FILL_W-1:0]               fold_cnt;
  logic [crc32cs_pkg::VEC_W-1:0]                fold_vec;
  logic [crc32cs_pkg::CRC_W-1:0]                folded;
  logic [crc32cs_pkg::GRP_W-1:0]                grp_bytes;

  // A complete swap group folds in reverse order; anything else folds in
  // arrival order, pending bytes first.
  assign full_grp = swap && (grp.fill == 2'd3);
  assign fold_en  = !swap || full_grp || last_byte;

  always_comb begin
    fold_cnt  = grp.fill;
    fold_data = '0;
    if (full_grp) begin
      fold_data = {grp.bytes[7:0], grp.bytes[15:8], grp.bytes[23:16], data_byte};
    end else begin
      case (grp.fill)
        2'd0:    fold_data = {24'h0, data_byte};
        2'd1:    fold_data = {16'h0, data_byte, grp.bytes[7:0]};
        2'd2:    fold_data = {8'h0, data_byte, grp.bytes[15:0]};
        default: fold_data = {data_byte, grp.bytes};
      endcase
    end
  end

  // Each output bit is the parity of the masked input vector.
  assign fold_vec = {fold_data, crc};

  always_comb begin
    for (int o = 0; o < crc32cs_pkg::CRC_W; o++) begin
      folded[o] = ^(fold_vec & crc32cs_pkg::CRC_ROWS[fold_cnt][o]);
    end
  end

  // Gathering a swap byte appends it above the pending bytes.
  always_comb begin
    case (grp.fill)
      2'd0:    grp_bytes = {16'h0, data_byte};
      2'd1:    grp_bytes = {8'h0, data_byte, grp.bytes[7:0]};
      default: grp_bytes = {data_byte, grp.bytes[15:0]};
    endcase
  end

  always_comb begin
    if (fold_en) begin
      crc_nxt = folded;
      grp_nxt = '0;
    end else begin
      crc_nxt       = crc;
      grp_nxt.bytes = grp_bytes;
      grp_nxt.fill  = grp.fill + 2'd1;
    end
  end

endmodule

>>> tb/sv/crc32c_swap_checker.sv
// Checker: watches the byte, result and register ports, predicts every CRC and compares.
`timescale 1ns / 1ps

module crc32c_swap_checker
  import crc32cs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CRC_W-1:0]     out_crc_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   crcs_outstanding
);

  // Mirror of the block's registers and message state.
  logic [CRC_W-1:0] seed_q;
  logic             swap_q;
  logic [CRC_W-1:0] crc_q;
  logic [GRP_W-1:0] grp_q;
  logic [1:0]       fill_q;

  // CRC values still owed by the block, oldest first.
  logic [CRC_W-1:0] crc_expect_q[$];

  // Reflected CRC-32C update with one byte, LSB first.
  function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {24'd0, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    return r;
  endfunction

  // Folds the held bytes of a partial group in arrival order.
  function automatic logic [CRC_W-1:0] crc32c_flush(input logic [CRC_W-1:0] crc,
                                                    input logic [GRP_W-1:0] grp,
                                                    input logic [1:0] fill);
    logic [CRC_W-1:0] r;
    r = crc;
    for (int i = 0; i < 3; i++) begin
      if (i < fill) r = crc32c_byte(r, grp[8*i +: 8]);
    end
    return r;
  endfunction

  // Advances the predicted state by one accepted byte.
  task automatic crc_take_byte(input logic [BYTE_W-1:0] b, input logic last);
    logic [CRC_W-1:0] c;
    c = crc_q;
    if (!swap_q) begin
      // Plain order; any bytes left from swap mode go first.
      c = crc32c_flush(c, grp_q, fill_q);
      c = crc32c_byte(c, b);
      grp_q = '0;
      fill_q = '0;
    end else if (fill_q == 2'd3) begin
      // A full group of four is folded newest byte first.
      c = crc32c_byte(c, b);
      c = crc32c_byte(c, grp_q[23:16]);
      c = crc32c_byte(c, grp_q[15:8]);
      c = crc32c_byte(c, grp_q[7:0]);
      grp_q = '0;
      fill_q = '0;
    end else if (last) begin
      // A short trailing group keeps its natural order.
      c = crc32c_flush(c, grp_q, fill_q);
      c = crc32c_byte(c, b);
      grp_q = '0;
      fill_q = '0;
    end else begin
      grp_q[8*fill_q +: 8] = b;
      fill_q = fill_q + 2'd1;
    end
    if (last) begin
      crc_expect_q = {crc_expect_q, c};
      crc_q = seed_q;
      grp_q = '0;
      fill_q = '0;
    end else begin
      crc_q = c;
    end
  endtask

  // Sample all channels at the rising edge.
  always @(posedge clk) begin
    logic [CRC_W-1:0] want;
    if (!rst_n) begin
      seed_q = '0;
      swap_q = 1'b0;
      crc_q = '0;
      grp_q = '0;
      fill_q = '0;
      crc_expect_q.delete();
      fail_count = 0;
    end else begin
      // Compare a delivered CRC with the oldest one owed.
      if (out_valid && !out_stall) begin
        if (crc_expect_q.size() == 0) begin
          $error("crc_result: expected none, actual %08h", out_crc_result);
          fail_count++;
        end else begin
          want = crc_expect_q.pop_front();
          if (out_crc_result !== want) begin
            $error("crc_result: expected %08h, actual %08h", want, out_crc_result);
            fail_count++;
          end
        end
      end
      // A seed write restarts the message; a mode write only changes the order.
      if (cfg_we) begin
        if (cfg_index == REG_SEED) begin
          seed_q = cfg_wdata;
          crc_q = cfg_wdata;
          grp_q = '0;
          fill_q = '0;
        end else if (cfg_index == REG_SWAP) begin
          swap_q = cfg_wdata[0];
        end
      end
      if (in_valid && !in_stall) crc_take_byte(in_data_byte, in_last_byte);
    end
    crcs_outstanding <= crc_expect_q.size();
  end

endmodule

>>> tb/sv/tb_crc32c_with_dword_swap_top.sv
// Testbench top: drives byte messages and register writes into the CRC block and reports.
`timescale 1ns / 1ps

module tb_crc32c_with_dword_swap_top;
  import crc32cs_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 8;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int PHASES       = 10;
  localparam int PHASE_BYTES  = 200;
  localparam int HOLD_PHASE   = 3;
  localparam int PAUSE_PHASE  = 5;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_last_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [CRC_W-1:0]     out_crc_result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRC_W-1:0]     cfg_wdata;

  int fail_count;
  int crcs_outstanding;
  int tx_gap_max = 8;
  int rx_gap_max = 8;
  bit long_hold_pending = 1'b0;
  int idle_cycles = 0;

  crc32c_with_dword_swap_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_crc_result (out_crc_result),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  crc32c_swap_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_crc_result   (out_crc_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .crcs_outstanding (crcs_outstanding)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each item, one long hold on request.
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        hold = LONG_HOLD;
        long_hold_pending = 1'b0;
      end else begin
        hold = $urandom_range(0, rx_gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one byte after a random gap and returns once it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Random bytes; the last one is marked only when the message is closed.
  task automatic send_message(input int len, input bit closed);
    for (int k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(0, 255)), closed && (k == len - 1));
    end
  endtask

  // Waits until every CRC has come out and the pipeline is empty.
  task automatic wait_crcs_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (crcs_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mode write with random upper bits, which the block must ignore.
  task automatic cfg_write_swap(input bit swap);
    logic [CRC_W-1:0] val;
    val = $urandom();
    val[0] = swap;
    cfg_write(REG_SWAP, val);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SEED;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte messages with the reset seed, extreme data values.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // All-ones seed in swap mode: one full group, then one group plus two.
    wait_crcs_drained();
    cfg_write(REG_SEED, 32'hFFFF_FFFF);
    cfg_write(REG_SWAP, 32'd1);
    for (int k = 0; k < 4; k++) send_byte(8'(8'h11 * (k + 1)), k == 3);
    for (int k = 0; k < 6; k++) send_byte(8'(8'hA0 + k), k == 5);

    // Swap bytes pending when plain mode returns mid-message.
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    wait_crcs_drained();
    cfg_write(REG_SWAP, 32'd0);
    send_byte(8'h7E, 1'b1);

    // Plain byte, then swap mode starts a group at the next byte.
    send_byte(8'h01, 1'b0);
    wait_crcs_drained();
    cfg_write(REG_SWAP, 32'd1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h02, 1'b1);

    // A seed write aborts a message in progress.
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    wait_crcs_drained();
    cfg_write(REG_SEED, 32'h1234_5678);
    send_byte(8'h55, 1'b1);

    // Random messages over a series of seeds and modes.
    for (int ph = 0; ph < PHASES; ph++) begin
      int sent;
      int len;
      bit hold_done;
      bit paused;
      logic [CRC_W-1:0] seed;
      bit swap;
      tx_gap_max = (ph == 2 || ph == 7 || ph == HOLD_PHASE) ? 0 : 8;
      rx_gap_max = (ph == 4 || ph == 7) ? 0 : 8;
      seed = (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom();
      swap = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
      wait_crcs_drained();
      // Sometimes only the mode changes, so an open message carries on.
      if (ph < 2 || $urandom_range(0, 3) != 0) cfg_write(REG_SEED, seed);
      cfg_write_swap(swap);
      sent = 0;
      hold_done = 1'b0;
      paused = 1'b0;
      while (sent < PHASE_BYTES) begin
        if (ph == HOLD_PHASE) len = $urandom_range(1, 2);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(13, 40);
        else len = $urandom_range(1, 12);
        send_message(len, 1'b1);
        sent += len;
        if (ph == HOLD_PHASE && !hold_done) begin
          long_hold_pending = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == PAUSE_PHASE && !paused && sent >= PHASE_BYTES / 2) begin
          wait_crcs_drained();
          paused = 1'b1;
        end
      end
      // Leave a message open across the next register change.
      if ($urandom_range(0, 1)) send_message($urandom_range(1, 3), 1'b0);
    end

    // Close out and give the verdict.
    send_message($urandom_range(1, 5), 1'b1);
    wait_crcs_drained();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
